// File: design/srts_pkg.sv
package srts_pkg;

    localparam int NUM_W     = 32;
    localparam int SYM_W     = 8;
    localparam int NUM_SYMS  = 16;
    localparam int DIGIT_W   = 4;
    localparam int RADIX_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int MAX_DIGITS = 32;
    localparam int DCNT_W    = 6;
    localparam int DIDX_W    = 5;

    typedef logic [SYM_W-1:0]     t_sym;
    typedef logic [DIGIT_W-1:0]   t_digit;
    typedef logic [NUM_W-1:0]     t_num;
    typedef logic [RADIX_W-1:0]   t_radix;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_sym SYM_ZERO  = 8'h00;
    localparam t_sym SYM_PLUS  = 8'h2B;
    localparam t_sym SYM_MINUS = 8'h2D;

    localparam t_cfg_idx CFG_RADIX        = 2'd0;
    localparam t_cfg_idx CFG_SYMBOLS_LOW  = 2'd1;
    localparam t_cfg_idx CFG_SYMBOLS_HIGH = 2'd2;

    typedef struct packed {
        logic   done;
        t_digit rem;
        logic   quot_zero;
    } t_div_status;

endpackage

// File: design/srts_div.sv
module srts_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  srts_pkg::t_num       i_dividend,
    input  srts_pkg::t_radix     i_divisor,
    output srts_pkg::t_num       o_quot,
    output srts_pkg::t_div_status o_status
);
    import srts_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIDX_W-1:0]     r_cnt;
    t_num                  r_q;
    t_digit                r_rem;
    t_radix                r_div;
    logic [RADIX_W-1:0]    trial;
    logic                  fits;
    logic [RADIX_W-1:0]    diff;

    assign trial = {r_rem, r_q[NUM_W-1]};
    assign fits  = (trial >= r_div);
    assign diff  = trial - r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIDX_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end
    end

    assign o_quot             = r_q;
    assign o_status.done      = r_done;
    assign o_status.rem       = r_rem;
    assign o_status.quot_zero = (r_q == '0);

endmodule

// File: design/signed_radix_to_symbols_top.sv
// A number is taken, then each digit comes from the shared bit-serial
// divider (one quotient bit a cycle), then the symbols go out, a minus sign
// first for a negative value, holding while the output stalls. No new number
// is taken until the last one is through. Invalid alphabets drop the number.
// Reset: synchronous active-low; clears control state and all three registers.
module signed_radix_to_symbols_top #(
    parameter int MAX_RADIX = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  srts_pkg::t_cfg_idx     i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic signed [31:0]     i_number,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_symbol,
    output logic                   o_last
);
    import srts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    t_radix                  r_radix;
    logic [CFG_W-1:0]        r_sym_lo;
    logic [CFG_W-1:0]        r_sym_hi;
    logic                    r_neg;
    logic [DCNT_W-1:0]       r_nd;
    logic [DIDX_W-1:0]       r_idx;
    t_digit                  r_digits [MAX_DIGITS];
    logic                    r_out_valid;
    t_sym                    r_symbol;
    logic                    r_last;

    logic [2*CFG_W-1:0]      alpha;
    t_sym                    syms [NUM_SYMS];
    logic                    alpha_ok;
    logic                    in_acc;
    logic                    out_free;
    logic                    div_start;
    t_num                    div_dividend;
    t_num                    div_quot;
    t_div_status             div_st;
    t_num                    in_mag;
    logic [DCNT_W-1:0]       nd_inc;
    logic                    div_finish;

    assign alpha = {r_sym_hi, r_sym_lo};

    always_comb begin
        for (int i = 0; i < NUM_SYMS; i++) begin
            syms[i] = alpha[i*SYM_W +: SYM_W];
        end
    end

    always_comb begin
        alpha_ok = (r_radix >= RADIX_W'(2)) && (r_radix <= RADIX_W'(MAX_RADIX))
                && (r_radix <= RADIX_W'(NUM_SYMS));
        for (int i = 0; i < NUM_SYMS; i++) begin
            if (RADIX_W'(i) < r_radix) begin
                if (syms[i] == SYM_ZERO || syms[i] == SYM_PLUS || syms[i] == SYM_MINUS)
                    alpha_ok = 1'b0;
                for (int j = i + 1; j < NUM_SYMS; j++) begin
                    if (RADIX_W'(j) < r_radix && syms[i] == syms[j])
                        alpha_ok = 1'b0;
                end
            end
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_mag     = i_number[NUM_W-1] ? (t_num'(0) - t_num'(i_number)) : t_num'(i_number);
    assign nd_inc     = r_nd + 1'b1;
    assign div_finish = div_st.quot_zero || (nd_inc == DCNT_W'(MAX_DIGITS));

    always_comb begin
        div_start    = 1'b0;
        div_dividend = div_quot;
        if (r_state == ST_IDLE) begin
            div_start    = in_acc && alpha_ok;
            div_dividend = in_mag;
        end else if (r_state == ST_DIV) begin
            div_start = div_st.done && !div_finish;
        end
    end

    srts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_radix),
        .o_quot     (div_quot),
        .o_status   (div_st)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && alpha_ok)
                    n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_st.done && div_finish)
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
                if (out_free)
                    n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && r_idx == '0)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_radix     <= '0;
            r_sym_lo    <= '0;
            r_sym_hi    <= '0;
            r_out_valid <= 1'b0;
            r_nd        <= '0;
            r_idx       <= '0;
            r_neg       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RADIX:        r_radix  <= i_cfg_data[RADIX_W-1:0];
                    CFG_SYMBOLS_LOW:  r_sym_lo <= i_cfg_data;
                    CFG_SYMBOLS_HIGH: r_sym_hi <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == ST_SIGN || r_state == ST_EMIT) && out_free)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_neg <= i_number[NUM_W-1];
                        r_nd  <= '0;
                    end
                end
                ST_DIV: begin
                    if (div_st.done) begin
                        r_nd  <= nd_inc;
                        r_idx <= r_nd[DIDX_W-1:0];
                    end
                end
                ST_EMIT: begin
                    if (out_free)
                        r_idx <= r_idx - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && div_st.done)
            r_digits[r_nd[DIDX_W-1:0]] <= div_st.rem;
        if (r_state == ST_SIGN && out_free) begin
            r_symbol <= SYM_MINUS;
            r_last   <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_symbol <= syms[r_digits[r_idx]];
            r_last   <= (r_idx == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import srts_pkg::*;

    localparam t_cfg_idx CFG_SPARE     = 2'd3;
    localparam int       SETTLE_CYCLES = 1100;

    localparam logic [63:0] DEC_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] DEC_HIGH = 64'h2D2B_00FF_2B2D_3938;
    localparam logic [63:0] BIN_LOW  = 64'h0000_2B2D_002D_3130;
    localparam logic [63:0] BIN_HIGH = 64'h2B2B_2B2B_2D2D_2D2D;
    localparam logic [63:0] HEX_LOW  = 64'h0706_0504_0302_FF01;
    localparam logic [63:0] HEX_HIGH = 64'h8040_200F_0E0D_0C0B;

    typedef struct {
        t_sym sym;
        logic last;
    } t_expect_sym;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    t_cfg_idx           i_cfg_index = CFG_RADIX;
    logic [63:0]        i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic signed [31:0] i_number    = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [7:0]         o_symbol;
    logic               o_last;

    t_radix      radix_q  = '0;
    logic [63:0] sym_lo_q = '0;
    logic [63:0] sym_hi_q = '0;

    t_expect_sym pending_syms[$];
    int          mismatches = 0;
    int          gap_pct    = 0;
    int          stall_pct  = 0;
    int          stall_left = 0;

    signed_radix_to_symbols_top #(
        .MAX_RADIX(NUM_SYMS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_number    (i_number),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int idle_len();
        if ($urandom_range(19) == 0) begin
            return $urandom_range(20, 50);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic t_sym sym_at(input int idx);
        return (idx < 8) ? sym_lo_q[8*idx +: 8] : sym_hi_q[8*(idx-8) +: 8];
    endfunction

    function automatic bit alphabet_valid();
        t_sym c;
        if (radix_q < 2 || radix_q > NUM_SYMS) begin
            return 1'b0;
        end
        for (int i = 0; i < radix_q; i++) begin
            c = sym_at(i);
            if (c == SYM_ZERO || c == SYM_PLUS || c == SYM_MINUS) begin
                return 1'b0;
            end
            for (int j = i + 1; j < radix_q; j++) begin
                if (sym_at(j) == c) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_symbols(input logic [31:0] value);
        logic [31:0]  mag;
        t_digit       digits [MAX_DIGITS];
        int           nd;
        t_expect_sym  e;
        if (!alphabet_valid()) begin
            return;
        end
        mag = value[31] ? 32'd0 - value : value;
        nd  = 0;
        do begin
            digits[nd] = t_digit'(mag % 32'(radix_q));
            nd++;
            mag = mag / 32'(radix_q);
        end while (mag != 0);
        if (value[31]) begin
            e.sym  = SYM_MINUS;
            e.last = 1'b0;
            pending_syms.push_back(e);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            e.sym  = sym_at(digits[k]);
            e.last = (k == 0);
            pending_syms.push_back(e);
        end
    endfunction

    function automatic logic [31:0] random_number();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6: begin
                v = $urandom_range(0, 40);
                if ($urandom_range(1)) v = -v;
            end
            7: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(1, 31);
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left  <= idle_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : out_check
        t_expect_sym want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_syms.size() == 0) begin
                report_mismatch($sformatf("unexpected symbol %h last %b", o_symbol, o_last));
            end else begin
                want = pending_syms.pop_front();
                if (o_symbol !== want.sym) begin
                    report_mismatch($sformatf("symbol %h, want %h", o_symbol, want.sym));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %b, want %b (symbol %h)",
                                              o_last, want.last, want.sym));
                end
            end
        end
    end

    task automatic send_number(input logic [31:0] value);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (!i_in_valid) begin
            i_in_valid <= 1'b1;
        end
        i_number <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_symbols(value);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_syms.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_RADIX:        radix_q  = data[RADIX_W-1:0];
            CFG_SYMBOLS_LOW:  sym_lo_q = data;
            CFG_SYMBOLS_HIGH: sym_hi_q = data;
            default: ;
        endcase
    endtask

    task automatic set_alphabet(input logic [63:0] radix_data, input logic [63:0] lo,
                                input logic [63:0] hi);
        settle_block();
        cfg_write(CFG_RADIX, radix_data);
        cfg_write(CFG_SYMBOLS_LOW, lo);
        cfg_write(CFG_SYMBOLS_HIGH, hi);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_alphabet();
        gap_pct   = 20;
        stall_pct = 20;
        send_number(32'd5);
        send_number(32'h8000_0000);
    endtask

    task automatic test_decimal();
        set_alphabet(64'd10, DEC_LOW, DEC_HIGH);
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        send_number(-32'sd987);
    endtask

    task automatic test_binary_extremes();
        set_alphabet(64'd2, BIN_LOW, BIN_HIGH);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'd0);
        send_number(32'hFFFF_FFFF);
    endtask

    task automatic test_full_radix();
        set_alphabet(64'd16, HEX_LOW, HEX_HIGH);
        send_number(32'h8000_0000);
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFF);
        send_number(32'h0123_4567);
    endtask

    task automatic test_ignored_index();
        settle_block();
        cfg_write(CFG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        i_cfg_we <= 1'b0;
        send_number(32'h89AB_CDEF);
    endtask

    task automatic test_bad_alphabets();
        set_alphabet(64'd0, DEC_LOW, DEC_HIGH);
        send_number(32'd42);
        set_alphabet(64'd1, DEC_LOW, DEC_HIGH);
        send_number(32'd42);
        set_alphabet(64'd17, HEX_LOW, HEX_HIGH);
        send_number(32'd42);
        set_alphabet(64'd31, HEX_LOW, HEX_HIGH);
        send_number(-32'sd42);
        set_alphabet(64'd10, {DEC_LOW[63:32], SYM_PLUS, DEC_LOW[23:0]}, DEC_HIGH);
        send_number(32'd42);
        set_alphabet(64'd10, {DEC_LOW[63:32], SYM_MINUS, DEC_LOW[23:0]}, DEC_HIGH);
        send_number(32'd42);
        set_alphabet(64'd10, {DEC_LOW[63:32], SYM_ZERO, DEC_LOW[23:0]}, DEC_HIGH);
        send_number(32'd42);
        set_alphabet(64'd10, DEC_LOW, {DEC_HIGH[63:16], DEC_LOW[7:0], DEC_HIGH[7:0]});
        send_number(32'd42);
    endtask

    task automatic test_random_numbers();
        int            counted;
        int            phase_len;
        int            i;
        int            j;
        bit            bad;
        bit            paused;
        bit            used [256];
        logic [4:0]    r;
        logic [7:0]    b;
        logic [63:0]   rdata;
        logic [127:0]  alpha;
        counted = 0;
        paused  = 1'b0;
        while (counted < 160) begin
            case ($urandom_range(3))
                0: gap_pct = 0;
                1: gap_pct = 10;
                2: gap_pct = 30;
                default: gap_pct = 60;
            endcase
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 10;
                2: stall_pct = 30;
                default: stall_pct = 60;
            endcase
            foreach (used[k]) used[k] = 1'b0;
            r     = 5'($urandom_range(2, NUM_SYMS));
            alpha = {$urandom, $urandom, $urandom, $urandom};
            for (i = 0; i < r; i++) begin
                do begin
                    b = 8'($urandom_range(1, 255));
                end while (b == SYM_PLUS || b == SYM_MINUS || used[b]);
                used[b]          = 1'b1;
                alpha[8*i +: 8] = b;
            end
            rdata = {$urandom, $urandom};
            bad   = ($urandom_range(99) < 15);
            if (bad) begin
                i = $urandom_range(0, r - 1);
                case ($urandom_range(4))
                    0: r = $urandom_range(0, 1) ? 5'($urandom_range(0, 1))
                                                : 5'($urandom_range(17, 31));
                    1: alpha[8*i +: 8] = SYM_PLUS;
                    2: alpha[8*i +: 8] = SYM_MINUS;
                    3: alpha[8*i +: 8] = SYM_ZERO;
                    default: begin
                        j = (i + $urandom_range(1, r - 1)) % r;
                        alpha[8*j +: 8] = alpha[8*i +: 8];
                    end
                endcase
            end
            rdata[4:0] = r;
            set_alphabet(rdata, alpha[63:0], alpha[127:64]);
            phase_len = $urandom_range(4, 16);
            repeat (phase_len) begin
                send_number(random_number());
                if (!bad) counted++;
            end
            if (!paused && counted >= 80) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_alphabet();
        test_decimal();
        test_binary_extremes();
        test_full_radix();
        test_ignored_index();
        test_bad_alphabets();
        test_random_numbers();
        settle_block();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
design/srts_pkg.sv
design/srts_div.sv
design/signed_radix_to_symbols_top.sv
bench/tb_top.sv
